// ===== rtl/arm64_reloc_immediate_patch_macros.svh =====
// Assertion helpers shared by the checker
`ifndef ARM64_RELOC_IMMEDIATE_PATCH_MACROS_SVH
`define ARM64_RELOC_IMMEDIATE_PATCH_MACROS_SVH

// Overlapping implication, sampled on clk, off while arst_n is low
`define A64RIP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define A64RIP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/a64rip_pkg.sv =====
package a64rip_pkg;

	// Default address width of the image
	localparam int ADDR_BITS_DEF = 64;

	// Relocation kinds
	localparam logic [3:0] MODE_ADDR32NB = 4'd0;
	localparam logic [3:0] MODE_BRANCH26 = 4'd1;
	localparam logic [3:0] MODE_BRANCH19 = 4'd2;
	localparam logic [3:0] MODE_BRANCH14 = 4'd3;
	localparam logic [3:0] MODE_PAGE21   = 4'd4;
	localparam logic [3:0] MODE_REL21    = 4'd5;
	localparam logic [3:0] MODE_PGOFF12L = 4'd6;
	localparam logic [3:0] MODE_PGOFF12A = 4'd7;
	localparam logic [3:0] MODE_SECREL   = 4'd8;

	// Bits kept when a field is reinserted
	localparam logic [31:0] KEEP_B26  = 32'hfc000000;
	localparam logic [31:0] KEEP_B19  = 32'hff00001f;
	localparam logic [31:0] KEEP_B14  = 32'hfff8001f;
	localparam logic [31:0] KEEP_ADR  = 32'h9f00001f;
	localparam logic [31:0] KEEP_LS12 = 32'hffc003ff;

	// 128-bit (q register) LDR/STR unsigned-offset opcode
	localparam logic [31:0] LDST_Q_MASK = 32'hff800000;
	localparam logic [31:0] LDST_Q_OPC  = 32'h3d800000;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] site_word;
		logic [63:0] section_base;
		logic [63:0] symbol_offset;
		logic [63:0] place_address;
	} reloc_in_t;

	typedef struct packed {
		logic [31:0] patched_word;
		logic        overflow;
	} reloc_out_t;

endpackage

// ===== rtl/arm64_reloc_immediate_patch.sv =====
// ARM64 PE/COFF relocation patcher.
// Input channel in_valid/in_stall/in_data carries one relocation per
// transaction: kind, site word, section base, symbol offset, site address.
// Output channel out_valid/out_stall/out_data returns the patched word and
// an overflow flag, one result per relocation, in order.
// Config channel cfg_valid/cfg_ready/cfg_data writes image_base; cfg_ready
// is always high. Write it only while no relocation is in flight.
// The input register captures the relocation with the target add; addend
// add, difference, range check and field insert then fill the output register.
// Throughput is one relocation per cycle, back to back, while out_stall is low.
// When out_stall is high the output register holds; the input register
// keeps filling while it has room, and in_stall rises once both are full.
// Reset clears both valids and sets image_base to zero.
// Unknown kinds return the site word unchanged with overflow set.
module arm64_reloc_immediate_patch #(
	parameter int ADDR_BITS = a64rip_pkg::ADDR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [63:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  a64rip_pkg::reloc_in_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output a64rip_pkg::reloc_out_t out_data
);

	typedef logic [ADDR_BITS-1:0] addr_t;

	// Configuration
	addr_t image_base_q;

	// Stage valids and advance enables
	logic valid_s1, valid_s2;
	logic adv1, adv2;

	// Stage 1 payload
	logic [3:0]  mode_s1;
	logic [31:0] word_s1;
	addr_t       dest_s1;
	logic [63:0] sym_s1;
	addr_t       place_s1;

	// Addend logic
	logic signed [27:0] imm_b26;
	logic signed [20:0] imm_b19;
	logic signed [15:0] imm_b14;
	logic signed [20:0] imm_adr;
	logic [11:0]        imm_ls;
	logic [2:0]         ls_shift_a;
	addr_t              addend;
	logic [63:0]        sum_d;

	// Result logic
	addr_t              tgt;
	addr_t              opa, opb, diff;
	logic [63:0]        diff_ext;
	logic [11:0]        lo12, lo_mask, ls_field;
	a64rip_pkg::reloc_out_t res_d;
	a64rip_pkg::reloc_out_t out_q;

	// True when d, sign-extended from ADDR_BITS, fits in n signed bits
	function automatic logic fits(input addr_t d, input int n);
		addr_t hi;
		hi = addr_t'($signed(d) >>> (n - 1));
		return (hi == '0) || (hi == '1);
	endfunction

	// Load/store access size shift from the instruction word
	function automatic logic [2:0] ls_shift(input logic [31:0] w);
		if ((w & a64rip_pkg::LDST_Q_MASK) == a64rip_pkg::LDST_Q_OPC)
			return 3'd4;
		else
			return {1'b0, w[31:30]};
	endfunction

	// Pipeline flow control
	assign adv2      = !valid_s2 || !out_stall;
	assign adv1      = !valid_s1 || adv2;
	assign in_stall  = !adv1;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data  = out_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			image_base_q <= '0;
		end else begin
			if (adv1)
				valid_s1 <= in_valid;
			if (adv2)
				valid_s2 <= valid_s1;
			if (cfg_valid && cfg_ready)
				image_base_q <= cfg_data[ADDR_BITS-1:0];
		end
	end

	// Stage 1: capture and form the target address
	always_ff @(posedge clk) begin
		if (adv1) begin
			mode_s1  <= in_data.mode;
			word_s1  <= in_data.site_word;
			dest_s1  <= in_data.section_base[ADDR_BITS-1:0]
				+ in_data.symbol_offset[ADDR_BITS-1:0];
			sym_s1   <= in_data.symbol_offset;
			place_s1 <= in_data.place_address[ADDR_BITS-1:0];
		end
	end

	// Extract the embedded addend and add it, or for SECREL add the site word to the symbol offset
	always_comb begin
		imm_b26    = {word_s1[25:0], 2'b00};
		imm_b19    = {word_s1[23:5], 2'b00};
		imm_b14    = {word_s1[18:5], 2'b00};
		imm_adr    = {word_s1[23:5], word_s1[30:29]};
		imm_ls     = word_s1[21:10];
		ls_shift_a = ls_shift(word_s1);
		addend     = '0;
		unique case (mode_s1) inside
			a64rip_pkg::MODE_ADDR32NB: addend = addr_t'($signed(word_s1));
			a64rip_pkg::MODE_BRANCH26: addend = addr_t'(imm_b26);
			a64rip_pkg::MODE_BRANCH19: addend = addr_t'(imm_b19);
			a64rip_pkg::MODE_BRANCH14: addend = addr_t'(imm_b14);
			a64rip_pkg::MODE_PAGE21, a64rip_pkg::MODE_REL21:
				addend = addr_t'(imm_adr);
			a64rip_pkg::MODE_PGOFF12L: addend = addr_t'(imm_ls) << ls_shift_a;
			a64rip_pkg::MODE_PGOFF12A: addend = addr_t'(imm_ls);
			default:                   addend = '0;
		endcase
		if (mode_s1 == a64rip_pkg::MODE_SECREL)
			sum_d = sym_s1 + 64'($signed(word_s1));
		else
			sum_d = 64'(dest_s1 + addend);
	end

	// Difference, range check and field insert
	always_comb begin
		tgt        = sum_d[ADDR_BITS-1:0];
		lo12       = sum_d[11:0];
		lo_mask    = (12'd1 << ls_shift_a) - 12'd1;
		ls_field   = lo12 >> ls_shift_a;
		unique case (mode_s1) inside
			a64rip_pkg::MODE_ADDR32NB: begin
				opa = tgt;
				opb = image_base_q;
			end
			a64rip_pkg::MODE_BRANCH26, a64rip_pkg::MODE_BRANCH19,
			a64rip_pkg::MODE_BRANCH14: begin
				opa = tgt >> 2;
				opb = place_s1 >> 2;
			end
			a64rip_pkg::MODE_PAGE21: begin
				opa = tgt >> 12;
				opb = place_s1 >> 12;
			end
			default: begin
				opa = tgt;
				opb = place_s1;
			end
		endcase
		diff     = opa - opb;
		diff_ext = 64'(diff);
		res_d    = '{patched_word: word_s1, overflow: 1'b1};
		unique case (mode_s1)
			a64rip_pkg::MODE_ADDR32NB: begin
				res_d.patched_word = diff_ext[31:0];
				res_d.overflow     = |diff_ext[63:32];
			end
			a64rip_pkg::MODE_BRANCH26: begin
				res_d.patched_word = (word_s1 & a64rip_pkg::KEEP_B26)
					| {6'd0, diff[25:0]};
				res_d.overflow     = !fits(diff, 26);
			end
			a64rip_pkg::MODE_BRANCH19: begin
				res_d.patched_word = (word_s1 & a64rip_pkg::KEEP_B19)
					| {8'd0, diff[18:0], 5'd0};
				res_d.overflow     = !fits(diff, 19);
			end
			a64rip_pkg::MODE_BRANCH14: begin
				res_d.patched_word = (word_s1 & a64rip_pkg::KEEP_B14)
					| {13'd0, diff[13:0], 5'd0};
				res_d.overflow     = !fits(diff, 14);
			end
			a64rip_pkg::MODE_PAGE21, a64rip_pkg::MODE_REL21: begin
				res_d.patched_word = (word_s1 & a64rip_pkg::KEEP_ADR)
					| {1'b0, diff[1:0], 5'd0, diff[20:2], 5'd0};
				res_d.overflow     = !fits(diff, 21);
			end
			a64rip_pkg::MODE_PGOFF12L: begin
				res_d.patched_word = (word_s1 & a64rip_pkg::KEEP_LS12)
					| {10'd0, ls_field, 10'd0};
				res_d.overflow     = |(lo12 & lo_mask);
			end
			a64rip_pkg::MODE_PGOFF12A: begin
				res_d.patched_word = (word_s1 & a64rip_pkg::KEEP_LS12)
					| {10'd0, lo12, 10'd0};
				res_d.overflow     = 1'b0;
			end
			a64rip_pkg::MODE_SECREL: begin
				res_d.patched_word = sum_d[31:0];
				res_d.overflow     = |sum_d[63:32];
			end
			default: begin
				// unknown kind: word passes through, flagged
				res_d = '{patched_word: word_s1, overflow: 1'b1};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv2)
			out_q <= res_d;
	end

endmodule

// ===== rtl/a64rip_checker.sv =====
`include "arm64_reloc_immediate_patch_macros.svh"

module a64rip_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input a64rip_pkg::reloc_in_t  in_data,
	input logic                   out_valid,
	input logic                   out_stall,
	input a64rip_pkg::reloc_out_t out_data
);

	// A stalled result stays offered
	`A64RIP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

	// A stalled result keeps its payload
	`A64RIP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))

	// With a free receiver an accepted transaction passes stage 1 and then reaches the output register
	`A64RIP_ASSERT_NXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid)

	// Unknown kinds pass the site word through and flag it
	`A64RIP_ASSERT_NXT(a_unknown,
		(in_valid && !in_stall && in_data.mode > a64rip_pkg::MODE_SECREL) ##1 !out_stall,
		out_data.overflow && out_data.patched_word == $past(in_data.site_word, 2))

endmodule

bind arm64_reloc_immediate_patch a64rip_checker u_a64rip_checker (.*);
